@@ hw/rtl/tcofq_pkg.sv @@
// shared constants, codes and types of the two-class oldest-first queue
package tcofq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int STAMP_BITS  = 17;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_BITS    = PTR_BITS + 1;

    // command codes
    localparam logic [1:0] CMD_ENQ     = 2'd0;
    localparam logic [1:0] CMD_DEQ0    = 2'd1;
    localparam logic [1:0] CMD_DEQ1    = 2'd2;
    localparam logic [1:0] CMD_DEQ_OLD = 2'd3;

    // result status codes
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_SERVED   = 2'd1;
    localparam logic [1:0] ST_NONE     = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [STAMP_BITS-1:0] stamp;
        logic [TAG_BITS-1:0]   tag;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_ctl;

endpackage

@@ hw/rtl/tcofq_in_if.sv @@
// command channel interface
interface tcofq_in_if;
    import tcofq_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic                item_class;
    logic [TAG_BITS-1:0] item_tag;

    modport source (output valid, output cmd, output item_class, output item_tag,
                    input ready);
    modport sink   (input valid, input cmd, input item_class, input item_tag,
                    output ready);
endinterface

@@ hw/rtl/tcofq_out_if.sv @@
// result channel interface
interface tcofq_out_if;
    import tcofq_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic                served_class;
    logic [TAG_BITS-1:0] served_tag;

    modport source (output valid, output status, output served_class, output served_tag,
                    input ready);
    modport sink   (input valid, input status, input served_class, input served_tag,
                    output ready);
endinterface

@@ hw/rtl/two_class_oldest_first_queue.sv @@
// top level of the two-class oldest-first queue
// a command transfer moves to the execute state, then to the result state
// one command in flight: accept, execute on the registered head reads, then present
//   the result; no new command is accepted until the result is taken
// reset: synchronous active low; clears heads, counts, stamp counter and state,
//   store contents stay undefined until written
module two_class_oldest_first_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcofq_in_if.sink    i_in,
    tcofq_out_if.source o_out
);
    import tcofq_pkg::*;

    t_ctl ctl;

    // sequencing
    tcofq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_ctl       (ctl)
    );

    // queues and result
    tcofq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_cmd          (i_in.cmd),
        .i_item_class   (i_in.item_class),
        .i_item_tag     (i_in.item_tag),
        .o_status       (o_out.status),
        .o_served_class (o_out.served_class),
        .o_served_tag   (o_out.served_tag)
    );

    // one command in flight: no new transfer while a result waits
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("command accepted while result pending");

    // a command transfer yields a result after the execute state
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> ##2 o_out.valid)
        else $error("result missing after command transfer");

    // execute cycle shows neither ready nor valid
    a_exec_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (!i_in.ready && !o_out.valid))
        else $error("handshake active during execute");

    // after the result transfer the block is ready again
    a_back_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> i_in.ready)
        else $error("not ready after result transfer");
endmodule

@@ hw/rtl/tcofq_ctrl.sv @@
// sequencing state machine: accept, execute, present result
module tcofq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output tcofq_pkg::t_ctl  o_ctl
);
    import tcofq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // handshake and datapath commands
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_ctl.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_ctl.exec  = (r_state == S_EXEC);
endmodule

@@ hw/rtl/tcofq_dp.sv @@
// datapath: two queue stores, pointers, stamp counter and result register
module tcofq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcofq_pkg::t_ctl               i_ctl,
    input  logic [1:0]                    i_cmd,
    input  logic                          i_item_class,
    input  logic [tcofq_pkg::TAG_BITS-1:0] i_item_tag,
    output logic [1:0]                    o_status,
    output logic                          o_served_class,
    output logic [tcofq_pkg::TAG_BITS-1:0] o_served_tag
);
    import tcofq_pkg::*;

    // queue stores
    t_entry r_mem0 [QUEUE_DEPTH];
    t_entry r_mem1 [QUEUE_DEPTH];
    t_entry r_rd0;
    t_entry r_rd1;

    logic [PTR_BITS-1:0]   r_head0, r_head1;
    logic [CNT_BITS-1:0]   r_count0, r_count1;
    logic [STAMP_BITS-1:0] r_stamp;

    // captured command
    logic [1:0]          r_cmd;
    logic                r_cls;
    logic [TAG_BITS-1:0] r_tag;

    // result register
    logic [1:0]          r_status;
    logic                r_res_class;
    logic [TAG_BITS-1:0] r_res_tag;

    logic                  empty0, empty1;
    logic [CNT_BITS-1:0]   enq_count;
    logic [PTR_BITS-1:0]   enq_head;
    logic [SUM_BITS-1:0]   pos_sum;
    logic [PTR_BITS-1:0]   wr_pos;
    logic                  enq_full;
    logic [STAMP_BITS-1:0] stamp_diff;
    logic                  want_serve;
    logic                  sel;
    logic                  sel_empty;
    logic                  do_enq, do_deq;
    logic [1:0]            n_status;
    logic                  n_res_class;
    logic [TAG_BITS-1:0]   n_res_tag;
    logic [PTR_BITS-1:0]   head_next0, head_next1;

    assign empty0 = (r_count0 == '0);
    assign empty1 = (r_count1 == '0);

    // write position of an enqueue, wrapped at the depth
    assign enq_count = r_cls ? r_count1 : r_count0;
    assign enq_head  = r_cls ? r_head1 : r_head0;
    assign enq_full  = (enq_count == CNT_BITS'(QUEUE_DEPTH));
    assign pos_sum   = SUM_BITS'(enq_head) + SUM_BITS'(enq_count);
    assign wr_pos    = (pos_sum >= SUM_BITS'(QUEUE_DEPTH))
                     ? PTR_BITS'(pos_sum - SUM_BITS'(QUEUE_DEPTH))
                     : PTR_BITS'(pos_sum);

    // modular stamp age compare of the two heads
    assign stamp_diff = r_rd0.stamp - r_rd1.stamp;

    // pick the class to serve
    always_comb begin
        want_serve = 1'b1;
        sel        = 1'b0;
        case (r_cmd)
            CMD_ENQ:  want_serve = 1'b0;
            CMD_DEQ0: sel = 1'b0;
            CMD_DEQ1: sel = 1'b1;
            CMD_DEQ_OLD: begin
                if (empty0 && empty1) begin
                    want_serve = 1'b0;
                end else if (empty1) begin
                    sel = 1'b0;
                end else if (empty0) begin
                    sel = 1'b1;
                end else begin
                    sel = (stamp_diff != '0) && !stamp_diff[STAMP_BITS-1];
                end
            end
            default: want_serve = 1'b0;
        endcase
    end

    assign sel_empty = sel ? empty1 : empty0;
    assign do_enq    = i_ctl.exec && (r_cmd == CMD_ENQ) && !enq_full;
    assign do_deq    = i_ctl.exec && want_serve && !sel_empty;

    // result value
    always_comb begin
        n_status    = ST_NONE;
        n_res_class = 1'b0;
        n_res_tag   = '0;
        if (r_cmd == CMD_ENQ) begin
            if (enq_full) begin
                n_status = ST_FULL;
            end else begin
                n_status    = ST_ENQUEUED;
                n_res_class = r_cls;
            end
        end else if (want_serve && !sel_empty) begin
            n_status    = ST_SERVED;
            n_res_class = sel;
            n_res_tag   = sel ? r_rd1.tag : r_rd0.tag;
        end
    end

    // head advance with wrap
    assign head_next0 = (r_head0 == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_head0 + 1'b1;
    assign head_next1 = (r_head1 == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_head1 + 1'b1;

    // stores: write on enqueue, registered head reads
    always_ff @(posedge i_clk) begin
        if (do_enq && !r_cls) r_mem0[wr_pos] <= '{stamp: r_stamp, tag: r_tag};
        if (do_enq && r_cls)  r_mem1[wr_pos] <= '{stamp: r_stamp, tag: r_tag};
        r_rd0 <= r_mem0[r_head0];
        r_rd1 <= r_mem1[r_head1];
    end

    // pointers, counts and stamp counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head0  <= '0;
            r_head1  <= '0;
            r_count0 <= '0;
            r_count1 <= '0;
            r_stamp  <= '0;
        end else begin
            if (do_enq) begin
                r_stamp <= r_stamp + 1'b1;
                if (r_cls) r_count1 <= r_count1 + 1'b1;
                else       r_count0 <= r_count0 + 1'b1;
            end
            if (do_deq) begin
                if (sel) begin
                    r_head1  <= head_next1;
                    r_count1 <= r_count1 - 1'b1;
                end else begin
                    r_head0  <= head_next0;
                    r_count0 <= r_count0 - 1'b1;
                end
            end
        end
    end

    // command capture and result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_cls <= i_item_class;
            r_tag <= i_item_tag;
        end
        if (i_ctl.exec) begin
            r_status    <= n_status;
            r_res_class <= n_res_class;
            r_res_tag   <= n_res_tag;
        end
    end

    assign o_status       = r_status;
    assign o_served_class = r_res_class;
    assign o_served_tag   = r_res_tag;
endmodule
